/* rtl/apm_pkg.sv */
// ----------------------------------------------------------------------------
// apm_pkg
// Shared constants, codes, tables and control types of the placement move
// evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package apm_pkg;

   localparam int GRID_SIDE     = 32;
   localparam int PIN_DEPTH     = 1024;
   localparam int CELL_COUNT    = 1024;

   localparam int ROW_BITS      = $clog2(GRID_SIDE);
   localparam int SITE_BITS     = 2 * ROW_BITS;
   localparam int SITE_COUNT    = GRID_SIDE * GRID_SIDE;
   localparam int CELL_BITS     = 10;
   localparam int COORD_BITS    = 5;
   localparam int DIM_BITS      = 6;
   localparam int CMP_BITS      = 8;
   localparam int PIN_ADDR_BITS = $clog2(PIN_DEPTH);
   localparam int PIN_CNT_BITS  = PIN_ADDR_BITS + 1;
   localparam int PIN_BITS      = CELL_BITS + 1;
   localparam int LEN_BITS      = 16;
   localparam int SPAN_BITS     = ROW_BITS + 1;
   localparam int TEMP_BITS     = 32;
   localparam int RND_BITS      = 16;
   localparam int LOG2E_BITS    = 17;
   localparam int PROD_BITS     = LEN_BITS + LOG2E_BITS;
   localparam int NUM_BITS      = PROD_BITS + 16;
   localparam int FACTOR_BITS   = 17;
   localparam int DIV_CNT_BITS  = $clog2(NUM_BITS + 1);
   localparam int CSR_ADDR_BITS = 2;

   localparam logic [LOG2E_BITS-1:0]    LOG2E_Q16  = LOG2E_BITS'(94548);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ROWS   = CSR_ADDR_BITS'(0);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COLS   = CSR_ADDR_BITS'(1);

   typedef enum logic [1:0] {
      OP_PLACE = 2'd0,
      OP_PIN   = 2'd1,
      OP_EVAL  = 2'd2,
      OP_SWAP  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_SITE = 2'd1,
      STATUS_PIN_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic clear_wr;
      logic take_req;
      logic latch_status;
      logic place_wr;
      logic pin_wr;
      logic rd_a;
      logic rd_b;
      logic load_va;
      logic load_vb;
      logic wr_a;
      logic wr_b;
      logic reverse;
      logic walk_start;
      logic mul_go;
      logic div_start;
      logic commit;
      logic rsp_load;
   } apm_cmd_type;

   typedef struct packed {
      logic   clear_last;
      op_type op;
      logic   sites_ok;
      logic   pin_full;
      logic   walk_done;
      logic   div_done;
      logic   keep;
      logic   rsp_free;
   } apm_stat_type;

   // 65536 * 2^(-k/16), rounded; the entry for k = 15 (34224) lies slightly above it
   function automatic logic [FACTOR_BITS-1:0] pow2_tab(input logic [3:0] k);
      logic [FACTOR_BITS-1:0] v;
      case (k)
         4'd0:    v = 17'd65536;
         4'd1:    v = 17'd62757;
         4'd2:    v = 17'd60097;
         4'd3:    v = 17'd57549;
         4'd4:    v = 17'd55109;
         4'd5:    v = 17'd52773;
         4'd6:    v = 17'd50535;
         4'd7:    v = 17'd48393;
         4'd8:    v = 17'd46341;
         4'd9:    v = 17'd44376;
         4'd10:   v = 17'd42495;
         4'd11:   v = 17'd40693;
         4'd12:   v = 17'd38968;
         4'd13:   v = 17'd37316;
         4'd14:   v = 17'd35734;
         4'd15:   v = 17'd34224;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* rtl/apm_if.sv */
// ----------------------------------------------------------------------------
// apm channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface apm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [9:0]  cell_id;
   logic [4:0]  first_row;
   logic [4:0]  first_col;
   logic [4:0]  second_row;
   logic [4:0]  second_col;
   logic        net_end;
   logic [31:0] temperature;
   logic [15:0] random_fraction;

   modport source (output valid, operation, cell_id, first_row, first_col, second_row,
                   second_col, net_end, temperature, random_fraction, input ready);
   modport sink   (input valid, operation, cell_id, first_row, first_col, second_row,
                   second_col, net_end, temperature, random_fraction, output ready);
endinterface

interface apm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] total_length;
   logic        accepted;
   logic [1:0]  status;

   modport source (output valid, total_length, accepted, status, input ready);
   modport sink   (input valid, total_length, accepted, status, output ready);
endinterface

interface apm_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [5:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/apm_div.sv */
// ----------------------------------------------------------------------------
// apm_div
// Restoring divider, one quotient bit per cycle, for the acceptance exponent.
// ----------------------------------------------------------------------------
`default_nettype none

module apm_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [apm_pkg::NUM_BITS-1:0]   numerator,
   input  wire logic [apm_pkg::TEMP_BITS-1:0]  divisor,
   output logic      [apm_pkg::NUM_BITS-1:0]   quotient,
   output logic                                done
);
   import apm_pkg::*;

   logic [NUM_BITS-1:0]     num_ff, num_in;
   logic [TEMP_BITS-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [TEMP_BITS:0]      trial;
   logic                    fits;

   assign trial = {rem_ff, num_ff[NUM_BITS-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numerator;
         rem_in  = '0;
         cnt_in  = DIV_CNT_BITS'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_BITS-2:0], fits};
         rem_in = fits ? TEMP_BITS'(trial - {1'b0, divisor}) : trial[TEMP_BITS-1:0];
         cnt_in = cnt_ff - DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = num_ff;
   assign done     = done_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while still busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");

endmodule

`default_nettype wire

/* rtl/apm_ctrl.sv */
// ----------------------------------------------------------------------------
// apm_ctrl
// Sequencer for clearing, place, pin append, evaluation and swap moves.
// ----------------------------------------------------------------------------
`default_nettype none

module apm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire apm_pkg::apm_stat_type stat,
   output apm_pkg::apm_cmd_type       cmd
);
   import apm_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_EXEC, S_RD_A, S_RD_B, S_LD_B, S_FWD_A, S_FWD_B,
      S_WALK, S_MUL, S_DIV, S_DIV_WAIT, S_DECIDE, S_REV_A, S_REV_B, S_RESP
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         case (state_ff)
            S_CLEAR:    if (stat.clear_last) state_ff <= S_IDLE;
            S_IDLE:     if (req_valid) state_ff <= S_EXEC;
            S_EXEC: begin
               case (stat.op)
                  OP_EVAL: state_ff <= S_WALK;
                  OP_SWAP: state_ff <= stat.sites_ok ? S_RD_A : S_RESP;
                  default: state_ff <= S_RESP;
               endcase
            end
            S_RD_A:     state_ff <= S_RD_B;
            S_RD_B:     state_ff <= S_LD_B;
            S_LD_B:     state_ff <= S_FWD_A;
            S_FWD_A:    state_ff <= S_FWD_B;
            S_FWD_B:    state_ff <= S_WALK;
            S_WALK: begin
               if (stat.walk_done) state_ff <= (stat.op == OP_EVAL) ? S_RESP : S_MUL;
            end
            S_MUL:      state_ff <= S_DIV;
            S_DIV:      state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: if (stat.div_done) state_ff <= S_DECIDE;
            S_DECIDE:   state_ff <= stat.keep ? S_RESP : S_REV_A;
            S_REV_A:    state_ff <= S_REV_B;
            S_REV_B:    state_ff <= S_RESP;
            S_RESP:     if (stat.rsp_free) state_ff <= S_IDLE;
            default:    state_ff <= S_CLEAR;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_CLEAR: cmd.clear_wr = 1'b1;
         S_IDLE:  cmd.take_req = req_valid;
         S_EXEC: begin
            cmd.latch_status = 1'b1;
            cmd.place_wr     = (stat.op == OP_PLACE) && stat.sites_ok;
            cmd.pin_wr       = (stat.op == OP_PIN) && !stat.pin_full;
            cmd.walk_start   = (stat.op == OP_EVAL);
         end
         S_RD_A:  cmd.rd_a = 1'b1;
         S_RD_B: begin
            cmd.rd_b    = 1'b1;
            cmd.load_va = 1'b1;
         end
         S_LD_B:  cmd.load_vb = 1'b1;
         S_FWD_A: cmd.wr_a = 1'b1;
         S_FWD_B: begin
            cmd.wr_b       = 1'b1;
            cmd.walk_start = 1'b1;
         end
         S_WALK:  cmd.commit = stat.walk_done && (stat.op == OP_EVAL);
         S_MUL:   cmd.mul_go = 1'b1;
         S_DIV:   cmd.div_start = 1'b1;
         S_DIV_WAIT: ;
         S_DECIDE: cmd.commit = stat.keep;
         S_REV_A: begin
            cmd.wr_a    = 1'b1;
            cmd.reverse = 1'b1;
         end
         S_REV_B: begin
            cmd.wr_b    = 1'b1;
            cmd.reverse = 1'b1;
         end
         S_RESP:  cmd.rsp_load = stat.rsp_free;
         default: cmd = '0;
      endcase
   end

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !stat.clear_last || state_ff == S_IDLE)
      else $error("ready outside idle");
   a_take_leads_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.take_req |=> state_ff == S_EXEC) else $error("accepted beat not executed");
   a_revert_after_reject: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REV_A) |-> $past(state_ff) == S_DECIDE)
      else $error("revert without decision");

endmodule

`default_nettype wire

/* rtl/apm_dp.sv */
// ----------------------------------------------------------------------------
// apm_dp
// Grid, cell site and pin memories, wirelength walk, acceptance arithmetic
// and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module apm_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire apm_pkg::apm_cmd_type               cmd,
   output apm_pkg::apm_stat_type                   stat,
   input  wire logic [1:0]                         in_operation,
   input  wire logic [apm_pkg::CELL_BITS-1:0]      in_cell_id,
   input  wire logic [apm_pkg::COORD_BITS-1:0]     in_first_row,
   input  wire logic [apm_pkg::COORD_BITS-1:0]     in_first_col,
   input  wire logic [apm_pkg::COORD_BITS-1:0]     in_second_row,
   input  wire logic [apm_pkg::COORD_BITS-1:0]     in_second_col,
   input  wire logic                               in_net_end,
   input  wire logic [apm_pkg::TEMP_BITS-1:0]      in_temperature,
   input  wire logic [apm_pkg::RND_BITS-1:0]       in_random_fraction,
   input  wire logic                               csr_valid,
   input  wire logic [apm_pkg::CSR_ADDR_BITS-1:0]  csr_index,
   input  wire logic [apm_pkg::DIM_BITS-1:0]       csr_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [apm_pkg::LEN_BITS-1:0]       rsp_total_length,
   output logic                                    rsp_accepted,
   output logic      [1:0]                         rsp_status
);
   import apm_pkg::*;

   // memories
   logic [CELL_BITS-1:0] grid_mem [SITE_COUNT];
   logic [SITE_BITS-1:0] cell_mem [CELL_COUNT];
   logic [PIN_BITS-1:0]  pin_mem  [PIN_DEPTH];

   // configuration
   logic [DIM_BITS-1:0] rows_ff, cols_ff;
   logic [CMP_BITS-1:0] rows_eff, cols_eff;

   // captured item
   op_type               op_ff;
   logic [CELL_BITS-1:0] id_ff;
   logic [COORD_BITS-1:0] r1_ff, c1_ff, r2_ff, c2_ff;
   logic                 end_ff;
   logic [TEMP_BITS-1:0] temp_ff;
   logic [RND_BITS-1:0]  rnd_ff;

   // control state
   logic [SITE_BITS-1:0]    clr_ff;
   logic [PIN_CNT_BITS-1:0] pin_count_ff;
   logic [LEN_BITS-1:0]     cur_ff;

   // swap
   logic [SITE_BITS-1:0] site_a, site_b;
   logic [CELL_BITS-1:0] grid_q_ff, va_ff, vb_ff;
   logic ok_a, ok_b;

   // walk
   logic                    walk_ff, p1_ff, p2_ff;
   logic [PIN_CNT_BITS-1:0] idx_ff;
   logic [PIN_BITS-1:0]     pin_q_ff;
   logic [SITE_BITS-1:0]    cell_q_ff;
   logic                    p2_zero_ff, p2_end_ff;
   logic                    open_ff;
   logic [ROW_BITS-1:0]     rmin_ff, rmax_ff, cmin_ff, cmax_ff;
   logic [ROW_BITS-1:0]     rmin_in, rmax_in, cmin_in, cmax_in;
   logic [LEN_BITS-1:0]     sum_ff, sum_in;
   logic [SITE_BITS-1:0]    pos;
   logic [ROW_BITS-1:0]     pr, pc;
   logic [SPAN_BITS-1:0]    span;
   logic [LEN_BITS:0]       sum_wide;
   logic                    issue, walk_done;

   // acceptance
   logic [LEN_BITS-1:0]    delta;
   logic [PROD_BITS-1:0]   prod_ff;
   logic [NUM_BITS-1:0]    quot;
   logic                   div_done;
   logic                   over;
   logic [FACTOR_BITS-1:0] factor;
   logic                   lower, keep;

   // result
   logic                rsp_valid_ff;
   logic [LEN_BITS-1:0] rsp_total_ff;
   logic                rsp_acc_ff, acc_ff;
   logic [1:0]          rsp_stat_ff;
   status_type          stat_ff, stat_in;

   always_comb begin
      if (rows_ff == '0) rows_eff = CMP_BITS'(1);
      else if (CMP_BITS'(rows_ff) > CMP_BITS'(GRID_SIDE)) rows_eff = CMP_BITS'(GRID_SIDE);
      else rows_eff = CMP_BITS'(rows_ff);
      if (cols_ff == '0) cols_eff = CMP_BITS'(1);
      else if (CMP_BITS'(cols_ff) > CMP_BITS'(GRID_SIDE)) cols_eff = CMP_BITS'(GRID_SIDE);
      else cols_eff = CMP_BITS'(cols_ff);
   end

   assign ok_a   = (CMP_BITS'(r1_ff) < rows_eff) && (CMP_BITS'(c1_ff) < cols_eff);
   assign ok_b   = (CMP_BITS'(r2_ff) < rows_eff) && (CMP_BITS'(c2_ff) < cols_eff);
   assign site_a = {ROW_BITS'(r1_ff), ROW_BITS'(c1_ff)};
   assign site_b = {ROW_BITS'(r2_ff), ROW_BITS'(c2_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_BITS'(1);
         cols_ff <= DIM_BITS'(1);
      end else if (csr_valid) begin
         if (csr_index == CSR_ROWS) rows_ff <= csr_data;
         if (csr_index == CSR_COLS) cols_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         op_ff   <= op_type'(in_operation);
         id_ff   <= in_cell_id;
         r1_ff   <= in_first_row;
         c1_ff   <= in_first_col;
         r2_ff   <= in_second_row;
         c2_ff   <= in_second_col;
         end_ff  <= in_net_end;
         temp_ff <= in_temperature;
         rnd_ff  <= in_random_fraction;
      end
   end

   // grid memory
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) grid_mem[clr_ff] <= '0;
      else if (cmd.place_wr) grid_mem[site_a] <= id_ff;
      else if (cmd.wr_a) grid_mem[site_a] <= cmd.reverse ? va_ff : vb_ff;
      else if (cmd.wr_b) grid_mem[site_b] <= cmd.reverse ? vb_ff : va_ff;
      grid_q_ff <= grid_mem[cmd.rd_b ? site_b : site_a];
      if (cmd.load_va) va_ff <= grid_q_ff;
      if (cmd.load_vb) vb_ff <= grid_q_ff;
   end

   // cell site memory
   always_ff @(posedge clock) begin
      if (cmd.place_wr) begin
         if (id_ff != '0) cell_mem[id_ff] <= site_a;
      end else if (cmd.wr_a) begin
         if (cmd.reverse) begin
            if (va_ff != '0) cell_mem[va_ff] <= site_a;
         end else begin
            if (vb_ff != '0) cell_mem[vb_ff] <= site_a;
         end
      end else if (cmd.wr_b) begin
         if (cmd.reverse) begin
            if (vb_ff != '0) cell_mem[vb_ff] <= site_b;
         end else begin
            if (va_ff != '0) cell_mem[va_ff] <= site_b;
         end
      end
      cell_q_ff <= cell_mem[pin_q_ff[CELL_BITS-1:0]];
   end

   // pin memory
   always_ff @(posedge clock) begin
      if (cmd.pin_wr) pin_mem[pin_count_ff[PIN_ADDR_BITS-1:0]] <= {end_ff, id_ff};
      pin_q_ff <= pin_mem[idx_ff[PIN_ADDR_BITS-1:0]];
   end

   // wirelength walk
   assign issue     = walk_ff && (idx_ff < pin_count_ff);
   assign walk_done = walk_ff && !issue && !p1_ff && !p2_ff;
   assign pos       = p2_zero_ff ? '0 : cell_q_ff;
   assign pr        = pos[SITE_BITS-1:ROW_BITS];
   assign pc        = pos[ROW_BITS-1:0];

   always_comb begin
      if (!open_ff) begin
         rmin_in = pr;
         rmax_in = pr;
         cmin_in = pc;
         cmax_in = pc;
      end else begin
         rmin_in = (pr < rmin_ff) ? pr : rmin_ff;
         rmax_in = (pr > rmax_ff) ? pr : rmax_ff;
         cmin_in = (pc < cmin_ff) ? pc : cmin_ff;
         cmax_in = (pc > cmax_ff) ? pc : cmax_ff;
      end
      span     = SPAN_BITS'(rmax_in - rmin_in) + SPAN_BITS'(cmax_in - cmin_in);
      sum_wide = {1'b0, sum_ff} + (LEN_BITS + 1)'(span);
      sum_in   = sum_wide[LEN_BITS] ? '1 : sum_wide[LEN_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      p2_zero_ff <= (pin_q_ff[CELL_BITS-1:0] == '0);
      p2_end_ff  <= pin_q_ff[CELL_BITS];
      if (cmd.walk_start) begin
         idx_ff  <= '0;
         sum_ff  <= '0;
      end else begin
         if (issue) idx_ff <= idx_ff + PIN_CNT_BITS'(1);
         if (p2_ff) begin
            rmin_ff <= rmin_in;
            rmax_ff <= rmax_in;
            cmin_ff <= cmin_in;
            cmax_ff <= cmax_in;
            if (p2_end_ff) sum_ff <= sum_in;
         end
      end
      if (reset) begin
         walk_ff <= 1'b0;
         p1_ff   <= 1'b0;
         p2_ff   <= 1'b0;
         open_ff <= 1'b0;
      end else begin
         p1_ff <= issue;
         p2_ff <= p1_ff;
         if (cmd.walk_start) begin
            walk_ff <= 1'b1;
            open_ff <= 1'b0;
         end else begin
            if (walk_done) walk_ff <= 1'b0;
            if (p2_ff) open_ff <= !p2_end_ff;
         end
      end
   end

   // acceptance test
   assign lower = sum_ff < cur_ff;
   assign delta = sum_ff - cur_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_go) prod_ff <= PROD_BITS'(delta) * PROD_BITS'(LOG2E_Q16);
   end

   apm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .numerator ({prod_ff, 16'd0}),
      .divisor   (temp_ff),
      .quotient  (quot),
      .done      (div_done)
   );

   assign over = quot[NUM_BITS-1:16] > (NUM_BITS - 16)'(16);

   always_comb begin
      if (delta == '0) factor = FACTOR_BITS'(65536);
      else if (temp_ff == '0) factor = '0;
      else if (over) factor = '0;
      else factor = pow2_tab(quot[15:12]) >> quot[20:16];
   end

   assign keep = lower || (factor > FACTOR_BITS'(rnd_ff));

   // status and counters
   always_comb begin
      stat_in = STATUS_OK;
      case (op_ff)
         OP_PLACE: if (!ok_a) stat_in = STATUS_BAD_SITE;
         OP_PIN:   if (pin_count_ff == PIN_CNT_BITS'(PIN_DEPTH)) stat_in = STATUS_PIN_FULL;
         OP_SWAP:  if (!(ok_a && ok_b)) stat_in = STATUS_BAD_SITE;
         default:  stat_in = STATUS_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_status) begin
         stat_ff <= stat_in;
         acc_ff  <= 1'b0;
      end else if (cmd.commit && op_ff == OP_SWAP) begin
         acc_ff <= 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_total_ff <= cur_ff;
         rsp_acc_ff   <= acc_ff;
      end
      if (reset) begin
         clr_ff       <= '0;
         pin_count_ff <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_wr) clr_ff <= clr_ff + SITE_BITS'(1);
         if (cmd.pin_wr) pin_count_ff <= pin_count_ff + PIN_CNT_BITS'(1);
         if (cmd.commit) cur_ff <= sum_ff;
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_stat_ff <= stat_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_length = rsp_total_ff;
   assign rsp_accepted     = rsp_acc_ff;
   assign rsp_status       = rsp_stat_ff;

   always_comb begin
      stat.clear_last = (clr_ff == '1);
      stat.op         = op_ff;
      stat.sites_ok   = (op_ff == OP_SWAP) ? (ok_a && ok_b) : ok_a;
      stat.pin_full   = (pin_count_ff == PIN_CNT_BITS'(PIN_DEPTH));
      stat.walk_done  = walk_done;
      stat.div_done   = div_done;
      stat.keep       = keep;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   a_pin_bound: assert property (@(posedge clock) disable iff (reset)
      pin_count_ff <= PIN_CNT_BITS'(PIN_DEPTH)) else $error("pin count past depth");
   a_pin_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && pin_count_ff != $past(pin_count_ff))
         |-> pin_count_ff == $past(pin_count_ff) + PIN_CNT_BITS'(1))
      else $error("pin count jumped");
   a_accept_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_acc_ff) |-> rsp_stat_ff == STATUS_OK)
      else $error("accepted move with error status");

endmodule

`default_nettype wire

/* rtl/annealing_placement_move_evaluator.sv */
// ----------------------------------------------------------------------------
// annealing_placement_move_evaluator
// Placement grid with netlist, half-perimeter wirelength and swap moves
// decided by an annealing acceptance test.
//
// req_bus carries one operation per beat: place cell, append pin, evaluate
// total wirelength, or try a swap of two sites. rsp_bus returns one beat per
// request with the current total, the accepted flag and a status code.
// csr_bus writes grid_rows (index 0) and grid_columns (index 1); it is always
// ready. It is to be written only while the block is idle; the block does not enforce this.
// Place, pin and a swap with a bad site go from the execute state straight to
// the response. Evaluate walks the pin list at one pin per cycle through the
// pin and cell site memories. A legal swap reads and swaps both sites, walks
// the pin list, then runs a one-bit-per-cycle divider for the exponent, and
// writes both sites back when the move is reverted.
// After reset all 1024 sites of the grid are cleared one site per cycle;
// req_bus.ready stays low until then. The result sits in an output register,
// so a stalled receiver holds the next result back in the final state, and
// one request is worked on at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module annealing_placement_move_evaluator (
   input wire logic clock,
   input wire logic reset,
   apm_req_if.sink   req_bus,
   apm_rsp_if.source rsp_bus,
   apm_csr_if.sink   csr_bus
);
   import apm_pkg::*;

   apm_cmd_type  cmd;
   apm_stat_type stat;

   assign csr_bus.ready = 1'b1;

   apm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   apm_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .in_operation       (req_bus.operation),
      .in_cell_id         (req_bus.cell_id),
      .in_first_row       (req_bus.first_row),
      .in_first_col       (req_bus.first_col),
      .in_second_row      (req_bus.second_row),
      .in_second_col      (req_bus.second_col),
      .in_net_end         (req_bus.net_end),
      .in_temperature     (req_bus.temperature),
      .in_random_fraction (req_bus.random_fraction),
      .csr_valid          (csr_bus.valid),
      .csr_index          (csr_bus.index),
      .csr_data           (csr_bus.data),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_total_length   (rsp_bus.total_length),
      .rsp_accepted       (rsp_bus.accepted),
      .rsp_status         (rsp_bus.status)
   );

endmodule

`default_nettype wire
